// ===== hw/rtl/vjp_pkg.sv =====
// ----------------------------------------------------------------------------
// vjp_pkg: shared types, constants and microprogram for the path counter
// Holds the control word layout, the step codes and the control store.
// ----------------------------------------------------------------------------
package vjp_pkg;

   localparam int REACH_W = 8;
   localparam int PATH_W  = 64;
   localparam int STEP_W  = 4;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type S_IDLE    = 4'd0;
   localparam step_type S_INIT    = 4'd1;
   localparam step_type S_NEXT    = 4'd2;
   localparam step_type S_RDWAIT  = 4'd3;
   localparam step_type S_LIMIT   = 4'd4;
   localparam step_type S_SUMTEST = 4'd5;
   localparam step_type S_ADD     = 4'd6;
   localparam step_type S_WRITE   = 4'd7;
   localparam step_type S_DONE    = 4'd8;
   localparam step_type S_FINISH  = 4'd9;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_LAST,
      C_I_ZERO,
      C_J_ZERO,
      C_RSP_BUSY
   } cond_type;

   typedef struct packed {
      logic accept;
      logic init;
      logic dec_i;
      logic rd_reach;
      logic lim_ld;
      logic rd_path;
      logic add;
      logic wr_path;
      logic finish;
   } ctrl_type;

   typedef struct packed {
      logic last_beat;
      logic i_zero;
      logic j_zero;
      logic rsp_busy;
   } stat_type;

   typedef struct packed {
      cond_type cond;
      step_type target;
      ctrl_type ctrl;
   } uword_type;

   function automatic uword_type rom_word(input step_type step);
      uword_type w;
      w = '{cond: C_NEVER, target: S_IDLE, ctrl: '0};
      case (step)
         S_IDLE: begin
            w.cond = C_NO_LAST;  w.target = S_IDLE;    w.ctrl.accept = 1'b1;
         end
         S_INIT: begin
            w.ctrl.init = 1'b1;
         end
         S_NEXT: begin
            w.cond = C_I_ZERO;   w.target = S_DONE;    w.ctrl.dec_i = 1'b1;
         end
         S_RDWAIT: begin
            w.ctrl.rd_reach = 1'b1;
         end
         S_LIMIT: begin
            w.ctrl.lim_ld = 1'b1;
         end
         S_SUMTEST: begin
            w.cond = C_J_ZERO;   w.target = S_WRITE;   w.ctrl.rd_path = 1'b1;
         end
         S_ADD: begin
            w.cond = C_ALWAYS;   w.target = S_SUMTEST; w.ctrl.add = 1'b1;
         end
         S_WRITE: begin
            w.cond = C_ALWAYS;   w.target = S_NEXT;    w.ctrl.wr_path = 1'b1;
         end
         S_DONE: begin
            w.cond = C_RSP_BUSY; w.target = S_DONE;
         end
         S_FINISH: begin
            w.cond = C_ALWAYS;   w.target = S_IDLE;    w.ctrl.finish = 1'b1;
         end
         default: begin
            w.cond = C_ALWAYS;   w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/vjp_seq.sv =====
// ----------------------------------------------------------------------------
// vjp_seq: microcode sequencer
// Step counter, control store lookup and conditional jump selection.
// ----------------------------------------------------------------------------
module vjp_seq (
   input  logic              clock,
   input  logic              reset,
   input  vjp_pkg::stat_type stat,
   output vjp_pkg::ctrl_type ctrl
);

   vjp_pkg::step_type  pc_ff, pc_in;
   vjp_pkg::uword_type word;
   logic               take;

   assign word = vjp_pkg::rom_word(pc_ff);
   assign ctrl = word.ctrl;

   always_comb begin
      case (word.cond)
         vjp_pkg::C_NEVER:    take = 1'b0;
         vjp_pkg::C_ALWAYS:   take = 1'b1;
         vjp_pkg::C_NO_LAST:  take = !stat.last_beat;
         vjp_pkg::C_I_ZERO:   take = stat.i_zero;
         vjp_pkg::C_J_ZERO:   take = stat.j_zero;
         vjp_pkg::C_RSP_BUSY: take = stat.rsp_busy;
         default:             take = 1'b1;
      endcase
      pc_in = take ? word.target : pc_ff + vjp_pkg::step_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= vjp_pkg::S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== hw/rtl/vjp_datapath.sv =====
// ----------------------------------------------------------------------------
// vjp_datapath: stair stores, accumulator and result register
// Loads stairs, runs the backward sum under microcode control, holds result.
// ----------------------------------------------------------------------------
module vjp_datapath #(
   parameter int MAX_STAIRS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  vjp_pkg::ctrl_type            ctrl,
   output vjp_pkg::stat_type            stat,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [vjp_pkg::REACH_W-1:0]  req_jump_reach,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [vjp_pkg::PATH_W-1:0]   rsp_path_count,
   output logic                         rsp_dropped
);

   localparam int CNT_W = $clog2(MAX_STAIRS + 1);
   localparam int IDX_W = (MAX_STAIRS > 1) ? $clog2(MAX_STAIRS) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_STAIRS);

   logic [vjp_pkg::REACH_W-1:0] reach_mem [MAX_STAIRS];
   logic [vjp_pkg::PATH_W-1:0]  path_mem  [MAX_STAIRS+1];

   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        drop_ff, drop_in;
   logic [CNT_W-1:0]            i_ff, i_in;
   logic [CNT_W-1:0]            k_ff, k_in;
   logic [CNT_W-1:0]            j_ff, j_in;
   logic [vjp_pkg::PATH_W-1:0]  acc_ff, acc_in;
   logic [vjp_pkg::REACH_W-1:0] reach_rd_ff;
   logic [vjp_pkg::PATH_W-1:0]  path_rd_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [vjp_pkg::PATH_W-1:0]  rsp_count_ff;
   logic                        rsp_drop_ff;

   logic                        beat;
   logic                        room;
   logic [CNT_W-1:0]            span;
   logic [CNT_W-1:0]            lim;
   logic                        path_we;
   logic [CNT_W-1:0]            path_wa;
   logic [vjp_pkg::PATH_W-1:0]  path_wd;

   assign req_ready = ctrl.accept;
   assign beat      = req_valid && ctrl.accept;
   assign room      = cnt_ff < CNT_MAX;

   assign stat.last_beat = beat && req_last;
   assign stat.i_zero    = i_ff == '0;
   assign stat.j_zero    = j_ff == '0;
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign span = cnt_ff - i_ff;
   assign lim  = (reach_rd_ff > vjp_pkg::REACH_W'(span)) ? span : CNT_W'(reach_rd_ff);

   always_comb begin
      cnt_in  = cnt_ff;
      drop_in = drop_ff;
      if (beat) begin
         if (room) cnt_in = cnt_ff + CNT_W'(1);
         else      drop_in = 1'b1;
      end
      if (ctrl.finish) begin
         cnt_in  = '0;
         drop_in = 1'b0;
      end

      i_in   = i_ff;
      k_in   = k_ff;
      j_in   = j_ff;
      acc_in = acc_ff;
      if (ctrl.init)  i_in = cnt_ff;
      if (ctrl.dec_i) i_in = i_ff - CNT_W'(1);
      if (ctrl.lim_ld) begin
         j_in   = lim;
         k_in   = i_ff + CNT_W'(1);
         acc_in = '0;
      end
      if (ctrl.add) begin
         j_in   = j_ff - CNT_W'(1);
         k_in   = k_ff + CNT_W'(1);
         acc_in = acc_ff + path_rd_ff;
      end

      path_we = ctrl.init || ctrl.wr_path;
      path_wa = ctrl.init ? cnt_ff : i_ff;
      path_wd = ctrl.init ? vjp_pkg::PATH_W'(1) : acc_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ctrl.finish) rsp_valid_in = 1'b1;
   end

   // memories
   always_ff @(posedge clock) begin
      if (beat && room) reach_mem[cnt_ff[IDX_W-1:0]] <= req_jump_reach;
      if (ctrl.rd_reach) reach_rd_ff <= reach_mem[i_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (path_we) path_mem[path_wa] <= path_wd;
      if (ctrl.rd_path && !stat.j_zero) path_rd_ff <= path_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      k_ff   <= k_in;
      j_ff   <= j_in;
      acc_ff <= acc_in;
      if (ctrl.finish) begin
         rsp_count_ff <= acc_ff;
         rsp_drop_ff  <= drop_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_count = rsp_count_ff;
   assign rsp_dropped    = rsp_drop_ff;

endmodule

// ===== hw/rtl/variable_jump_path_counter.sv =====
// ----------------------------------------------------------------------------
// variable_jump_path_counter: counts paths up a staircase with variable jumps
// Stairs load one beat per cycle while idle; the beat with req_last starts the count.
// ----------------------------------------------------------------------------
// Stair beats are taken one per cycle while idle. The beat marked last starts
// a backward pass run by a microcoded sequencer over one path-store read port:
// for each stored stair it steps the index down, reads the reach, loads the
// limit, tests and adds once per summed term, and writes the path count.
// Input is not taken during the pass. Stairs beyond MAX_STAIRS are dropped
// and flagged in rsp_dropped. The result waits in an output register, and
// loading of the next set may start while it is held.
// ----------------------------------------------------------------------------
module variable_jump_path_counter #(
   parameter int MAX_STAIRS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [vjp_pkg::REACH_W-1:0]  req_jump_reach,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [vjp_pkg::PATH_W-1:0]   rsp_path_count,
   output logic                         rsp_dropped
);

   vjp_pkg::ctrl_type ctrl;
   vjp_pkg::stat_type stat;

   vjp_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   vjp_datapath #(
      .MAX_STAIRS (MAX_STAIRS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .stat           (stat),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_jump_reach (req_jump_reach),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_path_count (rsp_path_count),
      .rsp_dropped    (rsp_dropped)
   );

endmodule
